FILE: hw/rtl/pdat_pkg.sv
// shared types and constants of the peer discovery aging table
package pdat_pkg;

    localparam int unsigned TableEntries = 16;
    localparam int unsigned TimeBits     = 32;
    localparam int unsigned EntryBits    = 48 + 32 + 16 + 16 + 8;

    // command codes
    localparam logic [1:0] CMD_HELLO  = 2'd0;
    localparam logic [1:0] CMD_TICK   = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;
    localparam logic [1:0] CMD_BEST   = 2'd3;

    // result event codes
    localparam logic [2:0] EV_UP       = 3'd0;
    localparam logic [2:0] EV_FORWARD  = 3'd1;
    localparam logic [2:0] EV_DOWN     = 3'd2;
    localparam logic [2:0] EV_FULL     = 3'd3;
    localparam logic [2:0] EV_BEACON   = 3'd4;
    localparam logic [2:0] EV_FOUND    = 3'd5;
    localparam logic [2:0] EV_NOTFOUND = 3'd6;

    // configuration register indexes
    localparam logic [2:0] REG_SYNC    = 3'd0;
    localparam logic [2:0] REG_OWN_IP  = 3'd1;
    localparam logic [2:0] REG_MASK    = 3'd2;
    localparam logic [2:0] REG_CINST   = 3'd3;
    localparam logic [2:0] REG_CTYPE   = 3'd4;
    localparam logic [2:0] REG_CMODE   = 3'd5;
    localparam logic [2:0] REG_LIFE    = 3'd6;
    localparam logic [2:0] REG_BEACON  = 3'd7;

    // one stored peer
    typedef struct packed {
        logic [47:0] uid;
        logic [31:0] ip;
        logic [15:0] inst;
        logic [15:0] ptype;
        logic [7:0]  pri;
    } t_entry;

    // configuration seen by the sequencer
    typedef struct packed {
        logic [31:0] sync_pattern;
        logic [31:0] own_ip;
        logic [31:0] subnet_mask;
        logic [15:0] control_instance;
        logic [15:0] control_type;
        logic        control_mode;
        logic [15:0] lifetime_ticks;
        logic [15:0] beacon_ticks;
    } t_cfg;

endpackage

FILE: hw/rtl/pdat_ram.sv
// generic ram with one write port and one registered read port
module pdat_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/pdat_cfg.sv
// apb configuration registers
module pdat_cfg
    import pdat_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg       r_cfg;
    logic [2:0] w_idx;
    logic       w_wr;

    assign w_idx  = paddr[4:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_pattern     <= '0;
            r_cfg.own_ip           <= '0;
            r_cfg.subnet_mask      <= 32'hFFFF_FF00;
            r_cfg.control_instance <= '0;
            r_cfg.control_type     <= '0;
            r_cfg.control_mode     <= 1'b0;
            r_cfg.lifetime_ticks   <= 16'd100;
            r_cfg.beacon_ticks     <= 16'd10;
        end else if (w_wr) begin
            case (w_idx)
                REG_SYNC:   r_cfg.sync_pattern     <= pwdata;
                REG_OWN_IP: r_cfg.own_ip           <= pwdata;
                REG_MASK:   r_cfg.subnet_mask      <= pwdata;
                REG_CINST:  r_cfg.control_instance <= pwdata[15:0];
                REG_CTYPE:  r_cfg.control_type     <= pwdata[15:0];
                REG_CMODE:  r_cfg.control_mode     <= pwdata[0];
                REG_LIFE:   r_cfg.lifetime_ticks   <= pwdata[15:0];
                REG_BEACON: r_cfg.beacon_ticks     <= pwdata[15:0];
                default:    r_cfg.sync_pattern     <= r_cfg.sync_pattern;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (w_idx)
            REG_SYNC:   prdata = r_cfg.sync_pattern;
            REG_OWN_IP: prdata = r_cfg.own_ip;
            REG_MASK:   prdata = r_cfg.subnet_mask;
            REG_CINST:  prdata = {16'd0, r_cfg.control_instance};
            REG_CTYPE:  prdata = {16'd0, r_cfg.control_type};
            REG_CMODE:  prdata = {31'd0, r_cfg.control_mode};
            REG_LIFE:   prdata = {16'd0, r_cfg.lifetime_ticks};
            REG_BEACON: prdata = {16'd0, r_cfg.beacon_ticks};
            default:    prdata = '0;
        endcase
    end

endmodule

FILE: hw/rtl/pdat_seq.sv
// scan sequencer with one shared compare unit over the entry memories
module pdat_seq
    import pdat_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = TableEntries,
    parameter int unsigned TIME_BITS     = TimeBits
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_start,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_sync_word,
    input  logic [31:0] i_src_ip,
    input  logic [47:0] i_peer_uid,
    input  logic [15:0] i_peer_instance,
    input  logic [15:0] i_peer_type,
    input  logic [7:0]  i_peer_priority,
    output logic        o_busy,
    output logic        o_valid,
    output logic [2:0]  o_event_res,
    output logic [3:0]  o_slot,
    output logic [47:0] o_out_uid,
    output logic [31:0] o_out_ip,
    output logic [15:0] o_out_instance,
    output logic [15:0] o_out_type,
    output logic [7:0]  o_out_priority,
    output logic        o_final_res
);

    localparam int unsigned IdxBits = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int unsigned CntBits = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CntBits-1:0] LastCnt = CntBits'(TABLE_ENTRIES);

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_CHECK, S_WRITE, S_DONE
    } t_state;

    t_state               r_state;
    logic [1:0]           r_cmd;
    t_entry               r_key;
    logic [CntBits-1:0]   r_idx;
    logic [TABLE_ENTRIES-1:0] r_used;
    logic [TIME_BITS-1:0] r_now;
    logic [TIME_BITS-1:0] r_beacon;
    logic                 r_hit;
    logic [IdxBits-1:0]   r_hit_idx;
    logic                 r_free_ok;
    logic [IdxBits-1:0]   r_free_idx;
    logic [7:0]           r_best_pri;
    logic                 r_pend;
    t_entry               r_pend_e;
    logic [2:0]           r_pend_ev;
    logic [3:0]           r_pend_slot;
    logic                 r_valid;
    logic [2:0]           r_ev;
    logic [3:0]           r_slot;
    t_entry               r_out;
    logic                 r_final;

    logic                 w_we;
    logic [IdxBits-1:0]   w_waddr;
    t_entry               w_wdata;
    logic [IdxBits-1:0]   w_raddr;
    logic [IdxBits-1:0]   w_cur;
    t_entry               w_rd;
    logic [TIME_BITS-1:0] w_rd_stamp;
    logic [TIME_BITS-1:0] w_age;
    logic                 w_uid_eq;
    logic                 w_pass;

    assign w_cur = r_idx[IdxBits-1:0];

    // entry and stamp memories
    pdat_ram #(.WIDTH(EntryBits), .DEPTH(TABLE_ENTRIES)) u_entry_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rd)
    );

    pdat_ram #(.WIDTH(TIME_BITS), .DEPTH(TABLE_ENTRIES)) u_stamp_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(r_now),
        .i_raddr(w_raddr),
        .o_rdata(w_rd_stamp)
    );

    // shared compare unit: uid match and age of the scanned entry
    assign w_uid_eq = (w_rd.uid == r_key.uid);
    assign w_age    = r_now - w_rd_stamp;
    assign w_raddr  = w_cur;
    assign w_wdata  = r_key;
    // a full table with no uid match writes nothing
    assign w_we     = (r_state == S_WRITE) && (r_hit || r_free_ok);
    assign w_waddr  = r_hit ? r_hit_idx : r_free_idx;

    assign w_pass = (i_sync_word == i_cfg.sync_pattern) &&
                    ((i_src_ip & i_cfg.subnet_mask) == (i_cfg.own_ip & i_cfg.subnet_mask));

    // sequencer, table state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= '0;
            r_now    <= '0;
            r_beacon <= '0;
            r_valid  <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_cmd        <= i_cmd;
                        r_key.uid    <= i_peer_uid;
                        r_key.ip     <= i_src_ip;
                        r_key.inst   <= i_peer_instance;
                        r_key.ptype  <= i_peer_type;
                        r_key.pri    <= i_peer_priority;
                        r_idx        <= '0;
                        r_hit        <= 1'b0;
                        r_hit_idx    <= '0;
                        r_free_ok    <= 1'b0;
                        r_free_idx   <= '0;
                        r_best_pri   <= '0;
                        r_pend       <= 1'b0;
                        r_state      <= S_READ;
                        if (i_cmd == CMD_HELLO) begin
                            if (!w_pass) begin
                                r_state <= S_IDLE;
                            end else if (i_peer_instance != i_cfg.control_instance) begin
                                r_state <= S_IDLE;
                                if (i_cfg.control_mode) begin
                                    r_valid     <= 1'b1;
                                    r_ev        <= EV_FORWARD;
                                    r_slot      <= '0;
                                    r_out.uid   <= i_peer_uid;
                                    r_out.ip    <= i_src_ip;
                                    r_out.inst  <= i_peer_instance;
                                    r_out.ptype <= i_peer_type;
                                    r_out.pri   <= i_peer_priority;
                                    r_final     <= 1'b1;
                                end
                            end
                        end else if (i_cmd == CMD_TICK) begin
                            r_now <= r_now + 1'b1;
                            if (i_cfg.control_mode &&
                                ((r_now + 1'b1 - r_beacon) >=
                                 TIME_BITS'(i_cfg.beacon_ticks))) begin
                                r_beacon    <= r_now + 1'b1;
                                r_pend      <= 1'b1;
                                r_pend_ev   <= EV_BEACON;
                                r_pend_slot <= '0;
                                r_pend_e    <= '0;
                            end
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    r_state <= S_READ;
                    r_idx   <= r_idx + 1'b1;
                    case (r_cmd)
                        CMD_HELLO: begin
                            if (!r_used[w_cur]) begin
                                if (!r_free_ok) begin
                                    r_free_ok  <= 1'b1;
                                    r_free_idx <= w_cur;
                                end
                            end else if (w_uid_eq) begin
                                r_hit     <= 1'b1;
                                r_hit_idx <= w_cur;
                                r_state   <= S_WRITE;
                            end
                        end
                        CMD_TICK: begin
                            if (r_used[w_cur] &&
                                w_age >= TIME_BITS'(i_cfg.lifetime_ticks)) begin
                                r_used[w_cur] <= 1'b0;
                                // emit previous pending result, hold this one
                                if (r_pend) begin
                                    r_valid <= 1'b1;
                                    r_ev    <= r_pend_ev;
                                    r_slot  <= r_pend_slot;
                                    r_out   <= r_pend_e;
                                    r_final <= 1'b0;
                                end
                                r_pend      <= 1'b1;
                                r_pend_ev   <= EV_DOWN;
                                r_pend_slot <= 4'(w_cur);
                                r_pend_e    <= w_rd;
                            end
                        end
                        CMD_LOOKUP: begin
                            if (r_used[w_cur] && w_uid_eq && !r_hit) begin
                                r_hit     <= 1'b1;
                                r_hit_idx <= w_cur;
                                r_pend_e  <= w_rd;
                            end
                        end
                        default: begin
                            if (r_used[w_cur] && w_rd.ptype == i_cfg.control_type &&
                                (!r_hit || w_rd.pri > r_best_pri)) begin
                                r_hit      <= 1'b1;
                                r_hit_idx  <= w_cur;
                                r_best_pri <= w_rd.pri;
                                r_pend_e   <= w_rd;
                            end
                        end
                    endcase
                    if (r_idx + 1'b1 == LastCnt && !(r_cmd == CMD_HELLO && r_used[w_cur]
                        && w_uid_eq)) begin
                        r_state <= (r_cmd == CMD_HELLO) ? S_WRITE : S_DONE;
                    end
                end
                S_WRITE: begin
                    r_state <= S_IDLE;
                    if (!r_hit) begin
                        r_valid <= 1'b1;
                        r_final <= 1'b1;
                        if (r_free_ok) begin
                            r_used[r_free_idx] <= 1'b1;
                            r_ev    <= EV_UP;
                            r_slot  <= 4'(r_free_idx);
                            r_out   <= r_key;
                        end else begin
                            r_ev    <= EV_FULL;
                            r_slot  <= '0;
                            r_out   <= '0;
                        end
                    end
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                    r_final <= 1'b1;
                    if (r_cmd == CMD_TICK) begin
                        r_valid <= r_pend;
                        r_ev    <= r_pend_ev;
                        r_slot  <= r_pend_slot;
                        r_out   <= r_pend_e;
                    end else begin
                        r_valid <= 1'b1;
                        r_ev    <= r_hit ? EV_FOUND : EV_NOTFOUND;
                        r_slot  <= r_hit ? 4'(r_hit_idx) : 4'd0;
                        r_out   <= r_hit ? r_pend_e : '0;
                    end
                    r_pend <= 1'b0;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign o_event_res    = r_ev;
    assign o_slot         = r_slot;
    assign o_out_uid      = r_out.uid;
    assign o_out_ip       = r_out.ip;
    assign o_out_instance = r_out.inst;
    assign o_out_type     = r_out.ptype;
    assign o_out_priority = r_out.pri;
    assign o_final_res    = r_final;

    // a write only happens after a scan step
    a_write_after_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> ($past(r_state) == S_CHECK))
        else $error("write state entered without a check");

    // a memory read is always followed by its check
    a_busy_no_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> (r_state == S_CHECK))
        else $error("memory read not followed by check");

    // time counter only moves on a tick
    a_now_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_now != $past(r_now)) |-> ($past(r_state) == S_IDLE && $past(i_start)
        && $past(i_cmd) == CMD_TICK))
        else $error("time counter moved without tick");

endmodule

FILE: hw/rtl/peer_discovery_aging_table.sv
// top level of the peer discovery aging table
//
// channel   direction  handshake             payload
// command   in         i_start & !o_busy     i_cmd, i_sync_word .. i_peer_priority
// result    out        o_valid (one cycle)   o_event_res .. o_final_res
// config    in         apb psel/penable      paddr, pwdata, prdata
//
// a hello, tick or query scans the entries through one shared compare unit,
// a read state then a check state per entry on the registered memory read;
// a hello stops at a uid match; a dropped or forwarded hello stays idle
// synchronous active-low reset empties the table and clears the time counter
// results cannot be stalled; each is shown for exactly one cycle
module peer_discovery_aging_table
    import pdat_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = TableEntries,
    parameter int unsigned TIME_BITS     = TimeBits
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_sync_word,
    input  logic [31:0] i_src_ip,
    input  logic [47:0] i_peer_uid,
    input  logic [15:0] i_peer_instance,
    input  logic [15:0] i_peer_type,
    input  logic [7:0]  i_peer_priority,
    output logic        o_valid,
    output logic [2:0]  o_event_res,
    output logic [3:0]  o_slot,
    output logic [47:0] o_out_uid,
    output logic [31:0] o_out_ip,
    output logic [15:0] o_out_instance,
    output logic [15:0] o_out_type,
    output logic [7:0]  o_out_priority,
    output logic        o_final_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg w_cfg;

    // configuration registers
    pdat_cfg u_cfg (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .o_cfg  (w_cfg)
    );

    // scan sequencer
    pdat_seq #(.TABLE_ENTRIES(TABLE_ENTRIES), .TIME_BITS(TIME_BITS)) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_start        (i_start),
        .i_cmd          (i_cmd),
        .i_sync_word    (i_sync_word),
        .i_src_ip       (i_src_ip),
        .i_peer_uid     (i_peer_uid),
        .i_peer_instance(i_peer_instance),
        .i_peer_type    (i_peer_type),
        .i_peer_priority(i_peer_priority),
        .o_busy         (o_busy),
        .o_valid        (o_valid),
        .o_event_res    (o_event_res),
        .o_slot         (o_slot),
        .o_out_uid      (o_out_uid),
        .o_out_ip       (o_out_ip),
        .o_out_instance (o_out_instance),
        .o_out_type     (o_out_type),
        .o_out_priority (o_out_priority),
        .o_final_res    (o_final_res)
    );

endmodule
